[design/mst_pkg.sv]
// ----------------------------------------------------------------------------
// mst_pkg
// Types and constants shared by the minimum spanning tree block.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int VTX_W   = 6;
    localparam int WGT_W   = 32;
    localparam int RANK_W  = 3;
    localparam int VCNT_W  = 7;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;

    typedef struct packed {
        logic [VTX_W-1:0] endpoint_a;
        logic [VTX_W-1:0] endpoint_b;
        logic [WGT_W-1:0] weight;
        logic             edge_present;
        logic             last_edge;
    } item_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_low;
        logic [VTX_W-1:0] vertex_high;
        logic [WGT_W-1:0] edge_weight;
        logic             tree_empty;
        logic             last_result;
    } result_t;

    typedef struct packed {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [WGT_W-1:0] w;
    } edge_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [VTX_W-1:0]  parent;
    } uf_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INIT,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_COMPRESS,
        S_JOIN,
        S_RANK,
        S_FLUSH
    } state_t;

endpackage

[design/minimum_spanning_tree_kruskal.sv]
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Kruskal minimum spanning tree with a sorted edge memory and union-find.
// ----------------------------------------------------------------------------
// Edges arrive one per transfer and are insertion-sorted into the edge memory.
// An edge keeps busy high while each stored edge heavier than it is read and
// moved up one slot, so the cost grows with the number of heavier edges.
// The single read port of that memory sets this cost. The transfer marked
// last_edge then sets up vertex_count union-find entries and walks the stored
// edges. Each edge follows the parent chains of both endpoints and writes back
// to the union-find memory; an edge that reaches beyond vertex_count is
// skipped. Busy stays high throughout. Results come out as one-cycle strobes
// on result_valid and cannot be held off; the final result carries last_result
// and appears in the cycle in which busy falls.
module minimum_spanning_tree_kruskal #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mst_pkg::item_t        item,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    output logic                  result_valid,
    output mst_pkg::result_t      result
);
    import mst_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int UAW = $clog2(MAX_VERTICES);

    state_t                 state_reg, state_next;
    logic [VCNT_W-1:0]      vc_reg;
    logic [ECW-1:0]         total_reg, total_next;
    logic [ECW-1:0]         pos_reg, pos_next;
    logic [ECW-1:0]         idx_reg, idx_next;
    logic [VCNT_W-1:0]      init_reg, init_next;
    edge_t                  new_reg, new_next;
    logic                   last_reg, last_next;
    edge_t                  cur_edge_reg, cur_edge_next;
    logic                   side_reg, side_next;
    logic                   first_reg, first_next;
    logic [VTX_W-1:0]       cur_reg, cur_next;
    logic [VTX_W-1:0]       x_reg, x_next;
    logic [RANK_W-1:0]      xrank_reg, xrank_next;
    logic [VTX_W-1:0]       ra_reg, ra_next, rb_reg, rb_next;
    logic [RANK_W-1:0]      rka_reg, rka_next, rkb_reg, rkb_next;
    result_t                pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    result_t                out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic [VCNT_W-1:0]      n_live;
    logic                   e_we;
    logic [EAW-1:0]         e_waddr, e_raddr;
    edge_t                  e_wdata, e_rdata;
    logic                   u_we;
    logic [UAW-1:0]         u_waddr, u_raddr;
    uf_entry_t              u_wdata, u_rdata;
    logic                   new_ok;
    logic [VTX_W-1:0]       root_sel;

    mst_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    mst_ram #(.WIDTH($bits(uf_entry_t)), .DEPTH(MAX_VERTICES), .AW(UAW)) u_uf_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    assign n_live = (vc_reg > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vc_reg;
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign new_ok = item.edge_present
                    && ({1'b0, item.endpoint_a} < n_live)
                    && ({1'b0, item.endpoint_b} < n_live)
                    && (total_reg < ECW'(MAX_EDGES));
    assign root_sel = side_reg ? rb_reg : ra_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vc_reg         <= 7'd64;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        init_reg     <= init_next;
        new_reg      <= new_next;
        last_reg     <= last_next;
        cur_edge_reg <= cur_edge_next;
        side_reg     <= side_next;
        first_reg    <= first_next;
        cur_reg      <= cur_next;
        x_reg        <= x_next;
        xrank_reg    <= xrank_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rka_reg      <= rka_next;
        rkb_reg      <= rkb_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        init_next       = init_reg;
        new_next        = new_reg;
        last_next       = last_reg;
        cur_edge_next   = cur_edge_reg;
        side_next       = side_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        x_next          = x_reg;
        xrank_next      = xrank_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        rka_next        = rka_reg;
        rkb_next        = rkb_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = 1'b0;
        e_we            = 1'b0;
        e_waddr         = pos_reg[EAW-1:0];
        e_wdata         = new_reg;
        e_raddr         = idx_reg[EAW-1:0];
        u_we            = 1'b0;
        u_waddr         = init_reg[UAW-1:0];
        u_wdata         = '0;
        u_raddr         = cur_reg[UAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next.a = item.endpoint_a;
                    new_next.b = item.endpoint_b;
                    new_next.w = item.weight;
                    last_next  = item.last_edge;
                    pos_next   = total_reg;
                    init_next  = '0;
                    if (new_ok)
                    begin
                        state_next = S_INS_RD;
                    end
                    else if (item.last_edge)
                    begin
                        state_next = S_INIT;
                    end
                end
            end

            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    e_we       = 1'b1;
                    total_next = total_reg + 1'b1;
                    state_next = last_reg ? S_INIT : S_IDLE;
                end
                else
                begin
                    e_raddr    = EAW'(pos_reg - 1'b1);
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                // Heavier entries move up one slot; equal weights stay ahead.
                e_we = 1'b1;
                if (e_rdata.w > new_reg.w)
                begin
                    e_wdata    = e_rdata;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                    state_next = last_reg ? S_INIT : S_IDLE;
                end
            end

            S_INIT:
            begin
                if (init_reg < n_live)
                begin
                    u_we           = 1'b1;
                    u_wdata.rank   = '0;
                    u_wdata.parent = VTX_W'(init_reg);
                    init_next      = init_reg + 1'b1;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_EDGE_RD;
                end
            end

            S_EDGE_RD:
            begin
                state_next = (idx_reg == total_reg) ? S_FLUSH : S_EDGE_CHK;
            end

            S_EDGE_CHK:
            begin
                cur_edge_next = e_rdata;
                idx_next      = idx_reg + 1'b1;
                if (({1'b0, e_rdata.a} < n_live) && ({1'b0, e_rdata.b} < n_live))
                begin
                    cur_next   = e_rdata.a;
                    x_next     = e_rdata.a;
                    side_next  = 1'b0;
                    first_next = 1'b1;
                    state_next = S_FIND_RD;
                end
                else
                begin
                    state_next = S_EDGE_RD;
                end
            end

            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end

            S_FIND_CHK:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    xrank_next = u_rdata.rank;
                end
                if (u_rdata.parent == cur_reg)
                begin
                    if (side_reg)
                    begin
                        rb_next  = cur_reg;
                        rkb_next = u_rdata.rank;
                    end
                    else
                    begin
                        ra_next  = cur_reg;
                        rka_next = u_rdata.rank;
                    end
                    if (cur_reg != x_reg)
                    begin
                        state_next = S_COMPRESS;
                    end
                    else if (side_reg)
                    begin
                        state_next = S_JOIN;
                    end
                    else
                    begin
                        side_next  = 1'b1;
                        cur_next   = cur_edge_reg.b;
                        x_next     = cur_edge_reg.b;
                        first_next = 1'b1;
                        state_next = S_FIND_RD;
                    end
                end
                else
                begin
                    cur_next   = u_rdata.parent;
                    state_next = S_FIND_RD;
                end
            end

            S_COMPRESS:
            begin
                // The start vertex is hooked straight onto its root.
                u_we           = 1'b1;
                u_waddr        = x_reg[UAW-1:0];
                u_wdata.rank   = xrank_reg;
                u_wdata.parent = root_sel;
                if (side_reg)
                begin
                    state_next = S_JOIN;
                end
                else
                begin
                    side_next  = 1'b1;
                    cur_next   = cur_edge_reg.b;
                    x_next     = cur_edge_reg.b;
                    first_next = 1'b1;
                    state_next = S_FIND_RD;
                end
            end

            S_JOIN:
            begin
                e_raddr    = idx_reg[EAW-1:0];
                state_next = S_EDGE_RD;
                if (ra_reg != rb_reg)
                begin
                    // The previous tree edge goes out now that it is known not to be last.
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_next.vertex_low  = (cur_edge_reg.a < cur_edge_reg.b) ?
                                            cur_edge_reg.a : cur_edge_reg.b;
                    pend_next.vertex_high = (cur_edge_reg.a < cur_edge_reg.b) ?
                                            cur_edge_reg.b : cur_edge_reg.a;
                    pend_next.edge_weight = cur_edge_reg.w;
                    pend_next.tree_empty  = 1'b0;
                    pend_next.last_result = 1'b0;
                    u_we = 1'b1;
                    if (rka_reg > rkb_reg)
                    begin
                        u_waddr        = rb_reg[UAW-1:0];
                        u_wdata.rank   = rkb_reg;
                        u_wdata.parent = ra_reg;
                    end
                    else
                    begin
                        u_waddr        = ra_reg[UAW-1:0];
                        u_wdata.rank   = rka_reg;
                        u_wdata.parent = rb_reg;
                        if ((rka_reg == rkb_reg) && (rkb_reg != RANK_MAX))
                        begin
                            state_next = S_RANK;
                        end
                    end
                end
            end

            S_RANK:
            begin
                u_we           = 1'b1;
                u_waddr        = rb_reg[UAW-1:0];
                u_wdata.rank   = rkb_reg + 1'b1;
                u_wdata.parent = rb_reg;
                state_next     = S_EDGE_RD;
            end

            S_FLUSH:
            begin
                out_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    out_next             = pend_reg;
                    out_next.last_result = 1'b1;
                end
                else
                begin
                    out_next             = '0;
                    out_next.tree_empty  = 1'b1;
                    out_next.last_result = 1'b1;
                end
                pend_valid_next = 1'b0;
                total_next      = '0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= ECW'(MAX_EDGES))
        else $error("edge count exceeds capacity");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy && total_reg == '0)
        else $error("final result without returning to idle");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.tree_empty |-> result.last_result)
        else $error("empty result not marked last");

    a_find_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIND_CHK |-> $past(state_reg) == S_FIND_RD)
        else $error("union-find read data used without a read");
`endif

endmodule

[design/mst_ram.sv]
// ----------------------------------------------------------------------------
// mst_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
